// File: hdl/mcspt_pkg.sv
// ----------------------------------------------------------------------------
// mcspt_pkg
// Shared types and constants for the multi-channel strobe pulse timer.
// ----------------------------------------------------------------------------
package mcspt_pkg;

  // Default channel count and microsecond clock width.
  localparam int CHANNELS_DEF  = 6;
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths of the stream words.
  localparam int CH_W    = 3;
  localparam int ARG_W   = 32;
  localparam int MASK_W  = 6;

  // Input word: channel, delay_us, width_us, padded to whole bytes.
  localparam int IN_FIELDS_W = CH_W + 2 * ARG_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // Result word: illumination_on, armed_mask, started_mask, ended_mask.
  localparam int OUT_FIELDS_W = 1 + 3 * MASK_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Item kind carried in tuser.
  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_ARM  = 1'b1
  } op_t;

endpackage

// File: hdl/multi_channel_strobe_pulse_timer.sv
// ----------------------------------------------------------------------------
// multi_channel_strobe_pulse_timer
// Multi-channel delayed strobe generator driving one shared illumination
// output, with stream input and result channels.
// ----------------------------------------------------------------------------
// The block returns exactly one result word for each word that it takes: the
// word is first captured in an input register, then all channel checks run in
// parallel and the result is loaded into the output register. An arm word
// (tuser = 1) stores the current microsecond time, a delay and a width for one
// channel; a tick word (tuser = 0) advances the time by one microsecond and
// checks the armed channels, channel 0 first, the last action within a tick
// deciding the light level. An arm word naming a channel that does not exist
// changes nothing but still returns a result. Throughput is one word per clock
// while the result side is not stalled, set by the single registered pass
// over all channel comparators.
module multi_channel_strobe_pulse_timer #(
  parameter int CHANNELS  = mcspt_pkg::CHANNELS_DEF,
  parameter int TIME_BITS = mcspt_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] channel, [34:3] delay_us, [66:35] width_us, upper bits zero.
  input  logic [mcspt_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] operation.
  input  logic [0:0]                        in_tuser,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] illumination_on, [6:1] armed_mask, [12:7] started_mask,
  // [18:13] ended_mask, upper bits zero.
  output logic [mcspt_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import mcspt_pkg::*;

  // Comparison width: holds the elapsed time and the unwrapped end time.
  localparam int CMP_W   = (TIME_BITS > ARG_W + 1) ? TIME_BITS : ARG_W + 1;
  localparam int PAD_W   = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;
  localparam int CHCMP_W = ($clog2(CHANNELS + 1) > CH_W) ? $clog2(CHANNELS + 1) : CH_W;

  // Input register.
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic [ARG_W-1:0]  s1_delay_r;
  logic [ARG_W-1:0]  s1_width_r;

  // Timer state.
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] edge_time_r   [CHANNELS];
  logic [ARG_W-1:0]     pulse_delay_r [CHANNELS];
  logic [ARG_W-1:0]     pulse_width_r [CHANNELS];
  logic [CHANNELS-1:0]  armed_r;
  logic [CHANNELS-1:0]  level_r;
  logic                 light_r;

  // Output register.
  logic                  out_valid_r;
  logic                  out_light_r;
  logic [MASK_W-1:0]     out_armed_r;
  logic [MASK_W-1:0]     out_started_r;
  logic [MASK_W-1:0]     out_ended_r;

  // Next values.
  logic [TIME_BITS-1:0] now_nxt;
  logic [CHANNELS-1:0]  armed_nxt;
  logic [CHANNELS-1:0]  level_nxt;
  logic                 light_nxt;
  logic [CHANNELS-1:0]  started_nxt;
  logic [CHANNELS-1:0]  ended_nxt;
  logic [CHANNELS-1:0]  arm_hit;

  // Per-channel comparison terms.
  logic [TIME_BITS-1:0] elapsed  [CHANNELS];
  logic [CMP_W-1:0]     end_time [CHANNELS];
  logic [CHANNELS-1:0]  past_delay;
  logic [CHANNELS-1:0]  past_end;

  logic advance;
  logic fire;

  // Handshake: the result register frees up when empty or being taken.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign fire      = s1_valid_r && advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r    <= op_t'(in_tuser[0]);
      s1_ch_r    <= in_tdata[CH_W-1:0];
      s1_delay_r <= in_tdata[CH_W +: ARG_W];
      s1_width_r <= in_tdata[CH_W + ARG_W +: ARG_W];
    end
  end

  // Channel checks, all in parallel, against the advanced clock.
  assign now_nxt = now_r + TIME_BITS'(1);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      elapsed[c]  = now_nxt - edge_time_r[c];
      end_time[c] = CMP_W'(pulse_delay_r[c]) + CMP_W'(pulse_width_r[c]);
      past_delay[c] = CMP_W'(elapsed[c]) >= CMP_W'(pulse_delay_r[c]);
      past_end[c]   = CMP_W'(elapsed[c]) >= end_time[c];
      arm_hit[c]    = (s1_op_r == OP_ARM) &&
                      (CHCMP_W'(s1_ch_r) == CHCMP_W'(c));
    end
  end

  // Start and end events, with the light decided by the last channel acting.
  always_comb begin
    armed_nxt   = armed_r;
    level_nxt   = level_r;
    light_nxt   = light_r;
    started_nxt = '0;
    ended_nxt   = '0;
    if (s1_op_r == OP_ARM) begin
      armed_nxt = armed_r | arm_hit;
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (armed_r[c]) begin
          if (past_delay[c] && !level_r[c]) begin
            started_nxt[c] = 1'b1;
            level_nxt[c]   = 1'b1;
            light_nxt      = 1'b1;
          end
          if (past_end[c] && (level_r[c] || started_nxt[c])) begin
            ended_nxt[c] = 1'b1;
            level_nxt[c] = 1'b0;
            armed_nxt[c] = 1'b0;
            light_nxt    = 1'b0;
          end
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r   <= '0;
      armed_r <= '0;
      level_r <= '0;
      light_r <= 1'b0;
    end else if (fire) begin
      if (s1_op_r == OP_TICK) begin
        now_r <= now_nxt;
      end
      armed_r <= armed_nxt;
      level_r <= level_nxt;
      light_r <= light_nxt;
    end
  end

  // Per-channel arm parameters; only read while the channel is armed.
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (fire && arm_hit[c]) begin
        edge_time_r[c]   <= now_r;
        pulse_delay_r[c] <= s1_delay_r;
        pulse_width_r[c] <= s1_width_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_light_r   <= light_nxt;
      out_armed_r   <= PAD_W'(armed_nxt) & PAD_W'({MASK_W{1'b1}});
      out_started_r <= PAD_W'(started_nxt) & PAD_W'({MASK_W{1'b1}});
      out_ended_r   <= PAD_W'(ended_nxt) & PAD_W'({MASK_W{1'b1}});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_ended_r, out_started_r, out_armed_r, out_light_r});

  // A channel that has ended its pulse is no longer armed.
  a_ended_disarms : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_ended_r & out_armed_r) == '0))
    else $error("ended channel still reported armed");

  // A channel that started without ending stays armed.
  a_started_armed : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_started_r & ~out_ended_r & ~out_armed_r) == '0))
    else $error("started channel not armed");

  // A strobe level is only held by an armed channel.
  a_level_armed : assert property (@(posedge clk) disable iff (!rst_n)
    (level_r & ~armed_r) == '0)
    else $error("strobe level high on a disarmed channel");

  // The clock only moves on an accepted tick.
  a_now_tick : assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && s1_op_r == OP_TICK) |=> $stable(now_r))
    else $error("time advanced without a tick");

  // With the input register empty, the input side is always ready.
  a_ready_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled while input register empty");

endmodule

// File: test/multi_channel_strobe_pulse_timer_tb.sv
// ----------------------------------------------------------------------------
// multi_channel_strobe_pulse_timer_tb
// Self-checking bench for the six-channel strobe timer. Arm and tick words go
// in on the input stream in random bursts. A local model of the channel timers
// predicts one result word per accepted input word. The result stream is
// checked field by field while its ready line stalls in changing patterns.
// ----------------------------------------------------------------------------
module multi_channel_strobe_pulse_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcspt_pkg::*;

  localparam int NUM_CH        = 6;
  localparam int RANDOM_WORDS  = 1950;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 10;

  // One word waiting to be sent, plus a flag that holds it back until the
  // result stream has fully drained.
  typedef struct {
    op_t         op;
    logic [2:0]  ch;
    logic [31:0] dly;
    logic [31:0] wid;
    bit          drain_first;
  } strobe_word_t;

  typedef struct packed {
    logic       light;
    logic [5:0] armed;
    logic [5:0] started;
    logic [5:0] ended;
  } strobe_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]            in_tuser = OP_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  strobe_word_t   pending_words[$];
  strobe_result_t expected_results[$];
  int             mismatch_count = 0;
  int             idle_cycles = 0;

  // Model state of the timer.
  logic [31:0] now_us;
  logic [31:0] edge_at[NUM_CH];
  logic [31:0] delay_q[NUM_CH];
  logic [31:0] width_q[NUM_CH];
  logic [5:0]  armed_q;
  logic [5:0]  level_q;
  logic        light_q;

  // Sender burst and receiver stall state.
  int         burst_left = 0;
  int         gap_left = 0;
  int         stall_mode = 0;
  logic [7:0] stall_phase = '0;

  multi_channel_strobe_pulse_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one word to the timer model and return the result it gives.
  function automatic strobe_result_t strobe_timer_step(op_t op, logic [2:0] ch,
                                                       logic [31:0] dly, logic [31:0] wid);
    strobe_result_t r;
    logic [31:0]    elapsed;
    logic [32:0]    end_at;
    r.started = '0;
    r.ended   = '0;
    if (op == OP_ARM) begin
      if (ch < NUM_CH) begin
        edge_at[ch] = now_us;
        delay_q[ch] = dly;
        width_q[ch] = wid;
        armed_q[ch] = 1'b1;
      end
    end else begin
      now_us = now_us + 32'd1;
      // Channel 0 first; the last channel to act sets the light.
      for (int c = 0; c < NUM_CH; c++) begin
        if (armed_q[c]) begin
          elapsed = now_us - edge_at[c];
          end_at  = {1'b0, delay_q[c]} + {1'b0, width_q[c]};
          if (elapsed >= delay_q[c] && !level_q[c]) begin
            light_q      = 1'b1;
            level_q[c]   = 1'b1;
            r.started[c] = 1'b1;
          end
          if ({1'b0, elapsed} >= end_at && level_q[c]) begin
            light_q    = 1'b0;
            level_q[c] = 1'b0;
            armed_q[c] = 1'b0;
            r.ended[c] = 1'b1;
          end
        end
      end
    end
    r.light = light_q;
    r.armed = armed_q;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  task automatic add_arm(logic [2:0] ch, logic [31:0] dly, logic [31:0] wid);
    strobe_word_t w;
    w.op = OP_ARM;
    w.ch = ch;
    w.dly = dly;
    w.wid = wid;
    w.drain_first = 1'b0;
    pending_words.push_back(w);
  endtask

  // A tick carries random junk in its unused fields.
  task automatic add_ticks(int n);
    strobe_word_t w;
    for (int i = 0; i < n; i++) begin
      w.op = OP_TICK;
      w.ch = 3'($urandom_range(0, 7));
      w.dly = $urandom;
      w.wid = $urandom;
      w.drain_first = 1'b0;
      pending_words.push_back(w);
    end
  endtask

  // Input driver: predicts each accepted word, then offers the next one.
  always @(posedge clk) begin
    strobe_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= OP_TICK;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(strobe_timer_step(op_t'(in_tuser), in_tdata[2:0],
                                                     in_tdata[34:3], in_tdata[66:35]));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_words[0].drain_first && expected_results.size() != 0) begin
          in_tvalid <= 1'b0;
        end else begin
          w = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, w.wid, w.dly, w.ch};
          in_tuser  <= w.op;
          // End of a burst: pick the next gap and burst length.
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              9:          gap_left = $urandom_range(10, 30);
              default:    gap_left = $urandom_range(1, 6);
            endcase
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Result ready pattern: a new mode is picked whenever the low seven bits of the phase counter wrap to zero.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 8'd1;
      if (stall_phase[6:0] == 7'd0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= stall_phase[0];
        2:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= (stall_phase[4:0] >= 5'd20);
      endcase
    end
  end

  // Result monitor: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    strobe_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result word 0x%0h with nothing expected", $realtime, out_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[0] !== want.light)
          report_mismatch("illumination_on", out_tdata[0], want.light);
        if (out_tdata[6:1] !== want.armed)
          report_mismatch("armed_mask", out_tdata[6:1], want.armed);
        if (out_tdata[12:7] !== want.started)
          report_mismatch("started_mask", out_tdata[12:7], want.started);
        if (out_tdata[18:13] !== want.ended)
          report_mismatch("ended_mask", out_tdata[18:13], want.ended);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("multi_channel_strobe_pulse_timer test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int          sel;
    logic [2:0]  ch;
    logic [31:0] dly;
    logic [31:0] wid;

    now_us  = '0;
    armed_q = '0;
    level_q = '0;
    light_q = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      edge_at[c] = '0;
      delay_q[c] = '0;
      width_q[c] = '0;
    end

    // Directed part.
    // Zero width: start and end on the same tick, light stays off.
    add_arm(3'd0, 32'd0, 32'd0);
    add_ticks(1);
    // Channel 0 ends as channel 5 starts in the same tick: light ends on.
    add_arm(3'd0, 32'd1, 32'd1);
    add_arm(3'd5, 32'd2, 32'd3);
    add_ticks(2);
    // Shared light: channel 1 ends while channel 2 still runs.
    add_arm(3'd1, 32'd0, 32'd1);
    add_arm(3'd2, 32'd0, 32'd8);
    add_ticks(3);
    // Re-arm channel 2 while its strobe is high.
    add_arm(3'd2, 32'd0, 32'd2);
    add_ticks(3);
    // Channels that do not exist, with all-ones fields.
    add_arm(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_arm(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Largest delay never starts; largest end sum never wraps to an early end.
    add_arm(3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_arm(3'd4, 32'd0, 32'hFFFF_FFFF);
    add_ticks(3);
    // Bring channels 3 and 4 back to short pulses.
    add_arm(3'd3, 32'd0, 32'd0);
    add_arm(3'd4, 32'd1, 32'd0);
    add_ticks(3);

    // Random part: mostly ticks with short arms mixed in.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        add_ticks(1);
      end else begin
        ch  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
          dly = $urandom;
          wid = $urandom;
        end else if (sel < 10) begin
          dly = $urandom_range(0, 8);
          wid = $urandom;
        end else begin
          dly = $urandom_range(0, 24);
          wid = $urandom_range(0, 24);
        end
        add_arm(ch, dly, wid);
      end
      // Hold the sender now and then until every result is back.
      if (i == 0 || $urandom_range(0, 399) == 0)
        pending_words[pending_words.size() - 1].drain_first = 1'b1;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("multi_channel_strobe_pulse_timer test passed");
    end else begin
      $display("multi_channel_strobe_pulse_timer test failed");
    end
    $finish;
  end

endmodule
